FILE: design/msmf_pkg.sv
// Shared types and constants of the masked sliding median filter.
package msmf_pkg;

  localparam int RADIUS_BITS = 5;
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RADIUS    = 1'b0,
    CFG_BAD_LEVEL = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_MASK,
    ST_SCAN,
    ST_PUSH
  } ctrl_state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic mask_load;
    logic scan_run;
    logic out_load;
    logic res_last;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: design/msmf_if.sv
// Request channel interfaces: input samples, filtered results, register writes.
interface msmf_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface msmf_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          last_out;
  modport source (output valid, filtered, last_out, input ready);
  modport sink (input valid, filtered, last_out, output ready);
endinterface

interface msmf_cfg_if #(parameter int SAMPLE_BITS = 24) ();
  logic                              valid;
  logic                              ready;
  logic [msmf_pkg::CFG_IDX_BITS-1:0] index;
  logic [SAMPLE_BITS-1:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/masked_sliding_median_filter_unit.sv
// Top level of the masked sliding median filter: register file, controller, datapath.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid / ready | sample, last
//   out_ch   | out | valid / ready | filtered, last_out
//   cfg_ch   | in  | valid / ready | index, data (0 radius, 1 bad_level)
//
// A request that yields no result only shifts its sample into the window. A request with a result
// passes accept, mask load, the rank scan and output load. Each flushed result adds a flush step,
// mask load, rank scan and output load, the rank scan rotating the whole window register past one
// comparator row, one candidate a cycle.
// Reset is synchronous, active low; registers come up radius 1, bad_level -1.
// The output register lets the next request enter while a result waits on out_ch.ready;
// a stalled output holds the controller only when a further result is ready to load.
module masked_sliding_median_filter_unit #(
  parameter int MAX_RADIUS = 16,
  parameter int SAMPLE_BITS = 24
) (
  input logic              clk,
  input logic              rst_n,
  msmf_in_if.sink          in_ch,
  msmf_out_if.source       out_ch,
  msmf_cfg_if.sink         cfg_ch
);

  localparam int IW = $clog2(2 * MAX_RADIUS + 1);

  logic [msmf_pkg::RADIUS_BITS-1:0] radius_r;
  logic signed [SAMPLE_BITS-1:0]    bad_r;
  msmf_pkg::dp_cmd_t                cmd;
  msmf_pkg::dp_sts_t                sts;
  logic [IW-1:0]                    lo, hi;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= msmf_pkg::RADIUS_BITS'(1);
      bad_r    <= '1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        msmf_pkg::CFG_RADIUS:    radius_r <= cfg_ch.data[msmf_pkg::RADIUS_BITS-1:0];
        msmf_pkg::CFG_BAD_LEVEL: bad_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  msmf_ctrl #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .radius   (radius_r),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .lo       (lo),
    .hi       (hi)
  );

  msmf_dpath #(
    .MAX_RADIUS (MAX_RADIUS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .lo           (lo),
    .hi           (hi),
    .sample       (in_ch.sample),
    .bad_level    (bad_r),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_filtered (out_ch.filtered),
    .out_last     (out_ch.last_out)
  );

`ifndef NO_ASSERTIONS
  a_no_shift_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !cmd.scan_run)
    else $error("sample request accepted during a window scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |=> !cmd.scan_run)
    else $error("scan continued past its last candidate");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending output");

  a_load_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mask_load |=> cmd.scan_run)
    else $error("mask load not followed by a scan");
`endif

endmodule

FILE: design/msmf_ctrl.sv
// Controller: stream bookkeeping, flush sequencing and datapath commands.
module msmf_ctrl #(
  parameter int MAX_RADIUS = 16,
  parameter int RW = $clog2(MAX_RADIUS + 1),
  parameter int IW = $clog2(2 * MAX_RADIUS + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [msmf_pkg::RADIUS_BITS-1:0] radius,
  input  logic                             in_valid,
  input  logic                             in_last,
  output logic                             in_ready,
  input  msmf_pkg::dp_sts_t                sts,
  output msmf_pkg::dp_cmd_t                cmd,
  output logic [IW-1:0]                    lo,
  output logic [IW-1:0]                    hi
);

  msmf_pkg::ctrl_state_t state_r, state_nxt;
  logic [RW-1:0] fill_r, fill_nxt;
  logic [RW-1:0] pend_r, pend_nxt;
  logic          last_r, last_nxt;
  logic          res_last_r, res_last_nxt;
  logic [IW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] hi_r, hi_nxt;
  logic [RW-1:0] r_eff;
  logic [RW-1:0] centre;

  assign r_eff = (radius > msmf_pkg::RADIUS_BITS'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius);
  assign centre = pend_r - 1'b1;
  assign lo = lo_r;
  assign hi = hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= msmf_pkg::ST_IDLE;
      fill_r     <= '0;
      pend_r     <= '0;
      last_r     <= 1'b0;
      res_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      pend_r     <= pend_nxt;
      last_r     <= last_nxt;
      res_last_r <= res_last_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    pend_nxt     = pend_r;
    last_nxt     = last_r;
    res_last_nxt = res_last_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    cmd          = '0;
    cmd.res_last = res_last_r;
    in_ready     = 1'b0;
    case (state_r)
      msmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift = 1'b1;
          last_nxt  = in_last;
          if (fill_r >= r_eff) begin
            lo_nxt       = '0;
            hi_nxt       = IW'(2 * r_eff);
            pend_nxt     = in_last ? r_eff : '0;
            res_last_nxt = in_last && (r_eff == '0);
            state_nxt    = msmf_pkg::ST_MASK;
          end else begin
            fill_nxt = fill_r + 1'b1;
            if (in_last) begin
              pend_nxt  = fill_r + 1'b1;
              state_nxt = msmf_pkg::ST_FLUSH;
            end
          end
        end
      end
      msmf_pkg::ST_FLUSH: begin
        lo_nxt       = (centre >= r_eff) ? IW'(centre - r_eff) : '0;
        hi_nxt       = IW'(centre) + IW'(r_eff);
        pend_nxt     = centre;
        res_last_nxt = last_r && (centre == '0);
        state_nxt    = msmf_pkg::ST_MASK;
      end
      msmf_pkg::ST_MASK: begin
        cmd.mask_load = 1'b1;
        state_nxt     = msmf_pkg::ST_SCAN;
      end
      msmf_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = msmf_pkg::ST_PUSH;
        end
      end
      msmf_pkg::ST_PUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (pend_r != '0) begin
            state_nxt = msmf_pkg::ST_FLUSH;
          end else begin
            if (last_r) begin
              cmd.clear = 1'b1;
              fill_nxt  = '0;
              last_nxt  = 1'b0;
            end
            state_nxt = msmf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = msmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/msmf_dpath.sv
// Datapath: sample window, counting mask, rotating rank scan and output register.
module msmf_dpath #(
  parameter int MAX_RADIUS = 16,
  parameter int SAMPLE_BITS = 24,
  parameter int IW = $clog2(2 * MAX_RADIUS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msmf_pkg::dp_cmd_t             cmd,
  output msmf_pkg::dp_sts_t             sts,
  input  logic [IW-1:0]                 lo,
  input  logic [IW-1:0]                 hi,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] bad_level,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_filtered,
  output logic                          out_last
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [CW-1:0] popc(input logic [DEPTH-1:0] v);
    logic [CW-1:0] s;
    s = '0;
    for (int i = 0; i < DEPTH; i++) s = s + CW'(v[i]);
    return s;
  endfunction

  logic signed [SAMPLE_BITS-1:0] win_r [DEPTH];
  logic [DEPTH-1:0]              vld_r;
  logic [DEPTH-1:0]              mask_r;
  logic [DEPTH-1:0]              lt_r, le_r;
  logic signed [SAMPLE_BITS-1:0] cand_r;
  logic                          cand_ok_r;
  logic [CW-1:0]                 cnt_r;
  logic [CW-1:0]                 n_r;
  logic signed [SAMPLE_BITS-1:0] med_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;
  logic                          out_last_r;

  logic signed [SAMPLE_BITS:0] limit;
  logic [DEPTH-1:0]            mask_nxt;
  logic [DEPTH-1:0]            lt_nxt, le_nxt;
  logic [CW-1:0]               below, upto, k;
  logic                        rot, evl;

  assign limit = {bad_level[SAMPLE_BITS-1], bad_level} + 1'b1;
  assign rot = cmd.scan_run && (cnt_r < CW'(DEPTH));
  assign evl = cmd.scan_run && (cnt_r != '0);
  assign below = popc(lt_r);
  assign upto = popc(le_r);
  assign k = CW'(({1'b0, n_r} + 1'b1) >> 1);

  assign sts.scan_done = cmd.scan_run && (cnt_r == CW'(DEPTH));
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_filtered = out_data_r;
  assign out_last = out_last_r;

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      mask_nxt[j] = vld_r[j] && (IW'(j) >= lo) && (IW'(j) <= hi) &&
                    ($signed({win_r[j][SAMPLE_BITS-1], win_r[j]}) > limit);
      lt_nxt[j] = mask_r[j] && (win_r[j] < win_r[0]);
      le_nxt[j] = mask_r[j] && (win_r[j] <= win_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cmd.clear) begin
        vld_r <= '0;
      end else if (cmd.shift) begin
        vld_r <= {vld_r[DEPTH-2:0], 1'b1};
      end
      if (cmd.mask_load) begin
        cnt_r <= '0;
      end else if (rot) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win_r[0] <= sample;
      for (int j = 1; j < DEPTH; j++) win_r[j] <= win_r[j-1];
    end else if (rot) begin
      win_r[DEPTH-1] <= win_r[0];
      for (int j = 0; j < DEPTH - 1; j++) win_r[j] <= win_r[j+1];
    end
    if (cmd.mask_load) begin
      mask_r <= mask_nxt;
    end else if (rot) begin
      mask_r <= {mask_r[0], mask_r[DEPTH-1:1]};
    end
    if (rot) begin
      lt_r      <= lt_nxt;
      le_r      <= le_nxt;
      cand_r    <= win_r[0];
      cand_ok_r <= mask_r[0];
    end
    if (cmd.scan_run && (cnt_r == '0)) begin
      n_r <= popc(mask_r);
    end
    if (evl && cand_ok_r && (below < k) && (k <= upto)) begin
      med_r <= cand_r;
    end
    if (cmd.out_load) begin
      out_data_r <= (n_r == '0) ? bad_level : med_r;
      out_last_r <= cmd.res_last;
    end
  end

endmodule

FILE: tb/masked_sliding_median_filter_unit_tb.sv
// Self-checking testbench of the masked sliding median filter: directed table, then random streams.
`timescale 1ns / 100ps

module masked_sliding_median_filter_unit_tb;

  localparam int SB           = 24;
  localparam int MAX_R        = 16;
  localparam int WIN_DEPTH    = 2 * MAX_R + 1;
  localparam int DRAIN_CYCLES = (2 * MAX_R + 4) + MAX_R + 16;
  localparam int RAND_ITEMS   = 360;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    logic signed [SB-1:0] filtered;
    logic                 last_out;
  } median_t;

  typedef struct {
    row_kind_t            kind;
    msmf_pkg::cfg_idx_t   idx;
    logic [SB-1:0]        data;
    logic                 last;
    bit                   typed;
    logic signed [SB-1:0] exp_val;
    logic                 exp_last;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic rx_ready = 1'b0;

  msmf_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  msmf_out_if #(.SAMPLE_BITS(SB)) out_ch ();
  msmf_cfg_if #(.SAMPLE_BITS(SB)) cfg_ch ();

  assign out_ch.ready = rx_ready;

  masked_sliding_median_filter_unit #(
    .MAX_RADIUS (MAX_R),
    .SAMPLE_BITS(SB)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic signed [SB-1:0] win_val [WIN_DEPTH];
  bit                   win_vld [WIN_DEPTH];
  int                   fill_cnt;
  logic [msmf_pkg::RADIUS_BITS-1:0] radius_reg;
  logic signed [SB-1:0] bad_reg;

  median_t   median_q [$];
  stim_row_t dir_rows [$];

  int  errors = 0;
  int  results_checked = 0;
  int  items_sent = 0;
  int  streams_closed = 0;
  int  reg_writes = 0;
  int  cycle_cnt = 0;
  int  rx_wait = 0;
  bit  rx_quiet = 1'b0;
  bit  tx_quiet = 1'b0;

  function automatic void clear_window();
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_val[i] = '0;
      win_vld[i] = 1'b0;
    end
    fill_cnt = 0;
  endfunction

  // ceil(n/2)-th smallest of the samples above bad_level+1 in slots lo..hi
  function automatic logic signed [SB-1:0] lower_median(int lo, int hi);
    int vals [WIN_DEPTH];
    int n, k, below, upto, lim;
    bit found;
    logic signed [SB-1:0] pick;
    n = 0;
    lim = int'(bad_reg) + 1;
    pick = bad_reg;
    found = 1'b0;
    for (int i = lo; i <= hi && i < WIN_DEPTH; i++) begin
      if (win_vld[i] && int'(win_val[i]) > lim) begin
        vals[n] = int'(win_val[i]);
        n++;
      end
    end
    if (n != 0) begin
      k = (n + 1) / 2;
      for (int i = 0; i < n && !found; i++) begin
        below = 0;
        upto = 0;
        for (int j = 0; j < n; j++) begin
          if (vals[j] < vals[i]) below++;
          if (vals[j] <= vals[i]) upto++;
        end
        if (below < k && k <= upto) begin
          pick = SB'(vals[i]);
          found = 1'b1;
        end
      end
    end
    return pick;
  endfunction

  function automatic void predict_medians(input logic signed [SB-1:0] s, input logic lst,
                                          ref median_t res [$]);
    int r, pend, ctr, lo;
    bit emitted;
    r = (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
      win_val[i] = win_val[i-1];
      win_vld[i] = win_vld[i-1];
    end
    win_val[0] = s;
    win_vld[0] = 1'b1;
    res.delete();
    emitted = (fill_cnt >= r);
    if (!emitted) fill_cnt++;
    pend = lst ? (emitted ? r : fill_cnt) : 0;
    if (emitted) res.push_back('{lower_median(0, 2 * r), lst && (pend == 0)});
    for (int c = pend; c > 0; c--) begin
      ctr = c - 1;
      lo = (ctr >= r) ? ctr - r : 0;
      res.push_back('{lower_median(lo, ctr + r), c == 1});
    end
    if (lst) clear_window();
  endfunction

  function automatic stim_row_t reg_row(msmf_pkg::cfg_idx_t idx, int v);
    stim_row_t row;
    row = '{ROW_CFG, idx, SB'(v), 1'b0, 1'b0, '0, 1'b0};
    return row;
  endfunction

  function automatic stim_row_t sample_row(int s, logic lst);
    stim_row_t row;
    row = '{ROW_SAMPLE, msmf_pkg::CFG_RADIUS, SB'(s), lst, 1'b0, '0, 1'b0};
    return row;
  endfunction

  function automatic stim_row_t known_row(int s, logic lst, int e, logic elst);
    stim_row_t row;
    row = '{ROW_SAMPLE, msmf_pkg::CFG_RADIUS, SB'(s), lst, 1'b1, SB'(e), elst};
    return row;
  endfunction

  task automatic send_sample(input logic signed [SB-1:0] s, input logic lst, input bit typed,
                             input logic signed [SB-1:0] exp_val, input logic exp_last);
    int gap;
    median_t res [$];
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= lst;
    do @(posedge clk); while (!in_ch.ready);
    predict_medians(s, lst, res);
    if (typed) median_q.push_back('{exp_val, exp_last});
    else foreach (res[i]) median_q.push_back(res[i]);
    items_sent++;
    if (lst) streams_closed++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input msmf_pkg::cfg_idx_t idx, input logic [SB-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == msmf_pkg::CFG_RADIUS) radius_reg = val[msmf_pkg::RADIUS_BITS-1:0];
    else bad_reg = val;
    reg_writes++;
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    logic signed [SB-1:0] s;
    case ($urandom_range(0, 5))
      0, 1: s = SB'($urandom());
      2: s = SB'(int'(bad_reg) + int'($urandom_range(0, 4)) - 2);
      3: s = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: s = SB'(int'($urandom_range(0, 2000)) - 1000);
    endcase
    return s;
  endfunction

  // result side: check each result against the oldest prediction, then a random hold-off
  always @(posedge clk) begin : rx_side
    median_t want;
    int hold;
    if (!rst_n) begin
      rx_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_ch.valid && rx_ready) begin
        if (median_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result filtered=%0d last_out=%0b", $time,
                   out_ch.filtered, out_ch.last_out);
        end else begin
          want = median_q.pop_front();
          results_checked++;
          if (out_ch.filtered !== want.filtered) begin
            errors++;
            $display("%0t: filtered mismatch, expected %0d, actual %0d", $time,
                     want.filtered, out_ch.filtered);
          end
          if (out_ch.last_out !== want.last_out) begin
            errors++;
            $display("%0t: last_out mismatch, expected %0b, actual %0b", $time,
                     want.last_out, out_ch.last_out);
          end
        end
        hold = rx_quiet ? 0 : $urandom_range(0, 10);
        rx_wait <= hold;
        rx_ready <= (hold == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        rx_ready <= (rx_wait == 1);
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
               median_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int rad, bad, r_eff, len, rand_cnt;
    bit close, open;
    logic signed [SB-1:0] s;

    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last   <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= msmf_pkg::CFG_RADIUS;
    cfg_ch.data  <= '0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    radius_reg = 5'd1;
    bad_reg = -24'sd1;
    clear_window();

    // after reset: radius 1, bad_level -1
    dir_rows.push_back(known_row(5, 1'b1, 5, 1'b1));
    dir_rows.push_back(sample_row(-8388608, 1'b0));
    dir_rows.push_back(sample_row(8388607, 1'b0));
    dir_rows.push_back(sample_row(0, 1'b1));
    // zero radius: one result per sample
    dir_rows.push_back(reg_row(msmf_pkg::CFG_RADIUS, 0));
    dir_rows.push_back(known_row(8388607, 1'b0, 8388607, 1'b0));
    dir_rows.push_back(known_row(-8388608, 1'b0, -1, 1'b0));
    dir_rows.push_back(known_row(1, 1'b1, 1, 1'b1));
    // threshold edges at both extremes of bad_level
    dir_rows.push_back(reg_row(msmf_pkg::CFG_BAD_LEVEL, -8388608));
    dir_rows.push_back(known_row(-8388608, 1'b1, -8388608, 1'b1));
    dir_rows.push_back(known_row(-8388607, 1'b1, -8388608, 1'b1));
    dir_rows.push_back(known_row(-8388606, 1'b1, -8388606, 1'b1));
    dir_rows.push_back(reg_row(msmf_pkg::CFG_BAD_LEVEL, 8388605));
    dir_rows.push_back(known_row(8388607, 1'b1, 8388607, 1'b1));
    dir_rows.push_back(known_row(8388606, 1'b1, 8388605, 1'b1));
    // short stream at full radius
    dir_rows.push_back(reg_row(msmf_pkg::CFG_RADIUS, 16));
    dir_rows.push_back(reg_row(msmf_pkg::CFG_BAD_LEVEL, -1));
    dir_rows.push_back(sample_row(3, 1'b0));
    dir_rows.push_back(sample_row(7, 1'b0));
    dir_rows.push_back(sample_row(-2, 1'b0));
    dir_rows.push_back(sample_row(9, 1'b1));
    // radius above the maximum is clamped
    dir_rows.push_back(reg_row(msmf_pkg::CFG_RADIUS, 31));
    dir_rows.push_back(sample_row(100, 1'b0));
    dir_rows.push_back(sample_row(-5, 1'b0));
    dir_rows.push_back(sample_row(200, 1'b1));
    // radius grows and bad_level moves while a stream is open
    dir_rows.push_back(reg_row(msmf_pkg::CFG_RADIUS, 2));
    dir_rows.push_back(sample_row(10, 1'b0));
    dir_rows.push_back(sample_row(20, 1'b0));
    dir_rows.push_back(sample_row(30, 1'b0));
    dir_rows.push_back(reg_row(msmf_pkg::CFG_RADIUS, 4));
    dir_rows.push_back(sample_row(40, 1'b0));
    dir_rows.push_back(sample_row(50, 1'b0));
    dir_rows.push_back(reg_row(msmf_pkg::CFG_BAD_LEVEL, 25));
    dir_rows.push_back(sample_row(60, 1'b1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                    dir_rows[i].exp_val, dir_rows[i].exp_last);
      end
    end

    rand_cnt = 0;
    open = 1'b0;
    while (rand_cnt < RAND_ITEMS) begin
      wait_drain();
      case ($urandom_range(0, 9))
        0: rad = 0;
        1: rad = MAX_R;
        2: rad = $urandom_range(MAX_R + 1, 31);
        default: rad = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 5))
        0: bad = -8388608;
        1: bad = 8388605;
        2: bad = -1;
        3: bad = int'($urandom_range(0, 16777213)) - 8388608;
        default: bad = int'($urandom_range(0, 600)) - 300;
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(msmf_pkg::CFG_RADIUS, SB'(rad));
        write_reg(msmf_pkg::CFG_BAD_LEVEL, SB'(bad));
      end else begin
        write_reg(msmf_pkg::CFG_BAD_LEVEL, SB'(bad));
        write_reg(msmf_pkg::CFG_RADIUS, SB'(rad));
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet <= ($urandom_range(0, 3) == 0);
      r_eff = (rad > MAX_R) ? MAX_R : rad;
      len = $urandom_range(1, 3 * r_eff + 8);
      if (len > RAND_ITEMS - rand_cnt) len = RAND_ITEMS - rand_cnt;
      close = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 39) == 0) wait_drain();
        s = rand_sample();
        send_sample(s, close && (j == len - 1), 1'b0, '0, 1'b0);
        rand_cnt++;
      end
      open = !close;
    end
    if (open) send_sample(rand_sample(), 1'b1, 1'b0, '0, 1'b0);

    wait_drain();
    if (median_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, median_q.size());
    end
    $display("Run covered %0d sample requests in %0d streams and %0d register writes;",
             items_sent, streams_closed, reg_writes);
    $display("%0d filtered results checked, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/msmf_pkg.sv
design/msmf_if.sv
design/msmf_ctrl.sv
design/msmf_dpath.sv
design/masked_sliding_median_filter_unit.sv
tb/masked_sliding_median_filter_unit_tb.sv
